>>> rtl/imh_pkg.sv
// ----------------------------------------------------------------------------
// imh_pkg
// shared constants, codes and request/result types of the indexed min-heap
// ----------------------------------------------------------------------------
`default_nettype none

package imh_pkg;

    localparam int NODE_W    = 10;
    localparam int KEY_W     = 32;
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 3;
    localparam int NODE_CAP  = 1024;
    localparam int NODE_SPAN = 1 << NODE_W;
    localparam int IDX_W     = $clog2(NODE_CAP);
    localparam int CNT_W     = IDX_W + 1;
    localparam int POS_W     = IDX_W + 1;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DEC    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd4;

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_INS  = 3'd0;
    localparam logic [OP_W-1:0] OP_POP  = 3'd1;
    localparam logic [OP_W-1:0] OP_DEC  = 3'd2;
    localparam logic [OP_W-1:0] OP_PEEK = 3'd3;
    localparam logic [OP_W-1:0] OP_QRY  = 3'd4;
    localparam logic [OP_W-1:0] OP_NOP  = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STAT_W-1:0] ST_PRESENT = 3'd3;
    localparam logic [STAT_W-1:0] ST_ABSENT  = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [NODE_W-1:0] node;
        logic [KEY_W-1:0]  key;
    } t_cmd;

    typedef struct packed {
        logic [NODE_W-1:0] out_node;
        logic [KEY_W-1:0]  out_key;
        logic              present;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  occupancy;
    } t_res;

endpackage

`default_nettype wire

>>> rtl/imh_front.sv
// ----------------------------------------------------------------------------
// imh_front
// request decoder and two-entry request queue ahead of the heap engine
// ----------------------------------------------------------------------------
`default_nettype none

module imh_front (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_push,
    input  wire  [imh_pkg::CMD_W-1:0]   i_command,
    input  wire  [imh_pkg::NODE_W-1:0]  i_node_id,
    input  wire  [imh_pkg::KEY_W-1:0]   i_key_value,
    output logic                        o_full,
    input  wire                         i_pop,
    output logic                        o_valid,
    output imh_pkg::t_cmd               o_cmd
);
    import imh_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_dec;
    logic       w_wr, w_rd;

    always_comb begin
        w_dec.node = i_node_id;
        w_dec.key  = i_key_value;
        case (i_command)
            CMD_INSERT: w_dec.op = OP_INS;
            CMD_POP:    w_dec.op = OP_POP;
            CMD_DEC:    w_dec.op = OP_DEC;
            CMD_PEEK:   w_dec.op = OP_PEEK;
            CMD_QUERY:  w_dec.op = OP_QRY;
            default:    w_dec.op = OP_NOP;
        endcase
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= w_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

endmodule

`default_nettype wire

>>> rtl/imh_engine.sv
// ----------------------------------------------------------------------------
// imh_engine
// heap sequencer: slot, key and position memories, sift up and sift down
// ----------------------------------------------------------------------------
`default_nettype none

module imh_engine (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cmd_valid,
    input  imh_pkg::t_cmd       i_cmd,
    output logic                o_cmd_pop,
    output logic                o_init_busy,
    input  wire                 i_res_full,
    output logic                o_res_push,
    output imh_pkg::t_res       o_res
);
    import imh_pkg::*;

    localparam logic [4:0] S_CLR    = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_POSCHK = 5'd2;
    localparam logic [4:0] S_UP_CHK = 5'd3;
    localparam logic [4:0] S_UP_RDK = 5'd4;
    localparam logic [4:0] S_UP_CMP = 5'd5;
    localparam logic [4:0] S_PLACE  = 5'd6;
    localparam logic [4:0] S_POP1   = 5'd7;
    localparam logic [4:0] S_POP2   = 5'd8;
    localparam logic [4:0] S_POP3   = 5'd9;
    localparam logic [4:0] S_DN_CHK = 5'd10;
    localparam logic [4:0] S_DN_RK1 = 5'd11;
    localparam logic [4:0] S_DN_RK2 = 5'd12;
    localparam logic [4:0] S_DN_CMP = 5'd13;
    localparam logic [4:0] S_PK1    = 5'd14;
    localparam logic [4:0] S_DONE   = 5'd15;
    localparam logic [4:0] S_PK2    = 5'd16;

    logic [NODE_W-1:0] heap_mem [NODE_CAP];
    logic [KEY_W-1:0]  key_mem  [NODE_SPAN];
    logic [POS_W-1:0]  pos_mem  [NODE_SPAN];

    logic [IDX_W-1:0]  heap_ra, heap_wa;
    logic [NODE_W-1:0] heap_wd, key_ra, key_wa, pos_ra, pos_wa;
    logic [KEY_W-1:0]  key_wd;
    logic [POS_W-1:0]  pos_wd;
    logic              heap_we, key_we, pos_we;

    logic [NODE_W-1:0] r_heap_q;
    logic [KEY_W-1:0]  r_key_q;
    logic [POS_W-1:0]  r_pos_q;

    logic [4:0]        r_state, n_state;
    logic [NODE_W-1:0] r_clr, n_clr;
    logic [OP_W-1:0]   r_op, n_op;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [IDX_W-1:0]  r_i, n_i;
    logic [NODE_W-1:0] r_n, n_n, r_c1n, n_c1n, r_c2n, n_c2n, r_onode, n_onode;
    logic [KEY_W-1:0]  r_k, n_k, r_c1k, n_c1k, r_okey, n_okey;
    logic              r_present, n_present;
    logic [STAT_W-1:0] r_status, n_status;

    logic [IDX_W-1:0]  w_parent;
    logic [CNT_W-1:0]  w_c1, w_c2;
    logic              w_node_ok, w_valid, w_take2;
    logic [NODE_W-1:0] w_nc;
    logic [KEY_W-1:0]  w_kc;
    logic [CNT_W-1:0]  w_ci;

    assign w_parent  = (r_i - 1'b1) >> 1;
    assign w_c1      = {r_i, 1'b1};
    assign w_c2      = w_c1 + 1'b1;
    assign w_node_ok = (32'(r_n) < NODE_CAP);
    assign w_valid   = r_pos_q[POS_W-1];
    assign w_take2   = (w_c2 < r_cnt) && !(r_c1k < r_key_q);
    assign w_nc      = w_take2 ? r_c2n : r_c1n;
    assign w_kc      = w_take2 ? r_key_q : r_c1k;
    assign w_ci      = w_take2 ? w_c2 : w_c1;

    assign o_init_busy = (r_state == S_CLR);
    assign o_cmd_pop   = (r_state == S_IDLE) && i_cmd_valid;
    assign o_res_push  = (r_state == S_DONE) && !i_res_full;
    assign o_res       = '{out_node: r_onode, out_key: r_okey, present: r_present,
                           status: r_status, occupancy: r_cnt};

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_op      = r_op;
        n_cnt     = r_cnt;
        n_i       = r_i;
        n_n       = r_n;
        n_k       = r_k;
        n_c1n     = r_c1n;
        n_c2n     = r_c2n;
        n_c1k     = r_c1k;
        n_onode   = r_onode;
        n_okey    = r_okey;
        n_present = r_present;
        n_status  = r_status;
        heap_ra   = '0;
        heap_we   = 1'b0;
        heap_wa   = r_i;
        heap_wd   = r_n;
        key_ra    = r_heap_q;
        key_we    = 1'b0;
        key_wa    = r_n;
        key_wd    = r_k;
        pos_ra    = r_n;
        pos_we    = 1'b0;
        pos_wa    = r_n;
        pos_wd    = {1'b1, r_i};
        case (r_state)
            S_CLR: begin
                pos_we = 1'b1;
                pos_wa = r_clr;
                pos_wd = '0;
                n_clr  = r_clr + 1'b1;
                if (r_clr == {NODE_W{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                pos_ra    = i_cmd.node;
                n_onode   = '0;
                n_okey    = '0;
                n_present = 1'b0;
                n_status  = ST_OK;
                if (i_cmd_valid) begin
                    n_op = i_cmd.op;
                    n_n  = i_cmd.node;
                    n_k  = i_cmd.key;
                    case (i_cmd.op)
                        OP_INS, OP_DEC, OP_QRY: n_state = S_POSCHK;
                        OP_POP, OP_PEEK: begin
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_DONE;
                            end else if (i_cmd.op == OP_POP) begin
                                n_state = S_POP1;
                            end else begin
                                n_state = S_PK1;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_POSCHK: begin
                n_state = S_DONE;
                case (r_op)
                    OP_INS: begin
                        if (!w_node_ok) begin
                            n_status = ST_ABSENT;
                        end else if (w_valid) begin
                            n_status = ST_PRESENT;
                        end else if (r_cnt == CNT_W'(NODE_CAP)) begin
                            n_status = ST_FULL;
                        end else begin
                            key_we  = 1'b1;
                            n_i     = r_cnt[IDX_W-1:0];
                            n_cnt   = r_cnt + 1'b1;
                            n_state = S_UP_CHK;
                        end
                    end
                    OP_DEC: begin
                        if (!w_node_ok || !w_valid) begin
                            n_status = ST_ABSENT;
                        end else begin
                            key_we  = 1'b1;
                            n_i     = r_pos_q[IDX_W-1:0];
                            n_state = S_UP_CHK;
                        end
                    end
                    default: n_present = w_node_ok && w_valid;
                endcase
            end
            S_UP_CHK: begin
                heap_ra = w_parent;
                n_state = (r_i == '0) ? S_PLACE : S_UP_RDK;
            end
            S_UP_RDK: begin
                n_c1n   = r_heap_q;
                n_state = S_UP_CMP;
            end
            S_UP_CMP: begin
                if (r_k < r_key_q) begin
                    heap_we = 1'b1;
                    heap_wd = r_c1n;
                    pos_we  = 1'b1;
                    pos_wa  = r_c1n;
                    n_i     = w_parent;
                    n_state = S_UP_CHK;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
                n_state = S_DONE;
            end
            S_POP1: begin
                n_onode = r_heap_q;
                heap_ra = IDX_W'(r_cnt - 1'b1);
                n_state = S_POP2;
            end
            S_POP2: begin
                n_okey = r_key_q;
                pos_we = 1'b1;
                pos_wa = r_onode;
                pos_wd = '0;
                n_cnt  = r_cnt - 1'b1;
                n_n    = r_heap_q;
                n_state = (r_cnt == CNT_W'(1)) ? S_DONE : S_POP3;
            end
            S_POP3: begin
                n_k     = r_key_q;
                n_i     = '0;
                n_state = S_DN_CHK;
            end
            S_DN_CHK: begin
                heap_ra = w_c1[IDX_W-1:0];
                n_state = (w_c1 >= r_cnt) ? S_PLACE : S_DN_RK1;
            end
            S_DN_RK1: begin
                n_c1n   = r_heap_q;
                heap_ra = w_c2[IDX_W-1:0];
                n_state = S_DN_RK2;
            end
            S_DN_RK2: begin
                n_c1k   = r_key_q;
                n_c2n   = r_heap_q;
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (w_kc < r_k) begin
                    heap_we = 1'b1;
                    heap_wd = w_nc;
                    pos_we  = 1'b1;
                    pos_wa  = w_nc;
                    n_i     = w_ci[IDX_W-1:0];
                    n_state = S_DN_CHK;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PK1: begin
                n_onode = r_heap_q;
                n_state = S_PK2;
            end
            S_PK2: begin
                n_okey  = r_key_q;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_res_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_heap_q <= heap_mem[heap_ra];
        if (heap_we) begin
            heap_mem[heap_wa] <= heap_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key_q <= key_mem[key_ra];
        if (key_we) begin
            key_mem[key_wa] <= key_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos_q <= pos_mem[pos_ra];
        if (pos_we) begin
            pos_mem[pos_wa] <= pos_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_i       <= n_i;
        r_n       <= n_n;
        r_k       <= n_k;
        r_c1n     <= n_c1n;
        r_c2n     <= n_c2n;
        r_c1k     <= n_c1k;
        r_onode   <= n_onode;
        r_okey    <= n_okey;
        r_present <= n_present;
        r_status  <= n_status;
    end

endmodule

`default_nettype wire

>>> rtl/imh_res_queue.sv
// ----------------------------------------------------------------------------
// imh_res_queue
// two-entry result queue between the heap engine and the receiver
// ----------------------------------------------------------------------------
`default_nettype none

module imh_res_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  imh_pkg::t_res       i_res,
    output logic                o_full,
    input  wire                 i_pop,
    output logic                o_empty,
    output imh_pkg::t_res       o_res
);
    import imh_pkg::*;

    t_res       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_wr, w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_res   = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

endmodule

`default_nettype wire

>>> rtl/indexed_min_heap.sv
// ----------------------------------------------------------------------------
// indexed_min_heap
// indexed binary min-heap of node ids with insert, pop, decrease-key, peek
// and presence query
// ----------------------------------------------------------------------------
// requests enter through a queue port: push while full is low; a two-entry
// request queue decouples the decoder from the heap engine
// results leave through a queue port: the oldest result is shown while empty
// is low and taken with pop; a two-entry result queue lets the engine start
// the next request while a result waits
// one request at a time in the engine; a new request is taken only after
// the last result has gone to the result queue; insert sifts up and pop
// sifts down one level per compare, each level paced by the single read
// port of the slot and key memories; peek, query, a rejected insert or
// decrease-key, an unused code and a pop or peek on an empty heap do no sift
// after reset the position memory is cleared one entry a cycle with full
// held high; a stalled receiver fills the result queue and then holds the
// engine, after which the request queue fills and raises full
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_min_heap (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           push,
    output logic                          full,
    input  wire  [imh_pkg::CMD_W-1:0]     i_command,
    input  wire  [imh_pkg::NODE_W-1:0]    i_node_id,
    input  wire  [imh_pkg::KEY_W-1:0]     i_key_value,
    output logic                          empty,
    input  wire                           pop,
    output logic [imh_pkg::NODE_W-1:0]    o_out_node,
    output logic [imh_pkg::KEY_W-1:0]     o_out_key,
    output logic                          o_present,
    output logic [imh_pkg::STAT_W-1:0]    o_status,
    output logic [imh_pkg::CNT_W-1:0]     o_occupancy
);
    import imh_pkg::*;

    t_cmd w_cmd;
    t_res w_res, w_out;
    logic w_front_full, w_cmd_valid, w_cmd_pop, w_init_busy;
    logic w_res_push, w_res_full;

    assign full = w_front_full || w_init_busy;

    imh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push && !w_init_busy),
        .i_command   (i_command),
        .i_node_id   (i_node_id),
        .i_key_value (i_key_value),
        .o_full      (w_front_full),
        .i_pop       (w_cmd_pop),
        .o_valid     (w_cmd_valid),
        .o_cmd       (w_cmd)
    );

    imh_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_init_busy (w_init_busy),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    imh_res_queue u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_res   (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_res   (w_out)
    );

    assign o_out_node  = w_out.out_node;
    assign o_out_key   = w_out.out_key;
    assign o_present   = w_out.present;
    assign o_status    = w_out.status;
    assign o_occupancy = w_out.occupancy;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_occupancy <= CNT_W'(NODE_CAP)))
        else $error("occupancy beyond capacity");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == ST_EMPTY) |-> (o_out_node == '0 && o_out_key == '0
                                              && o_occupancy == '0))
        else $error("empty status with payload");

    a_present_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_present) |-> (o_status == ST_OK && o_occupancy != '0))
        else $error("present with bad status or empty heap");
`endif

endmodule

`default_nettype wire
